// ===== rtl/isc_pkg.sv =====
package isc_pkg;

   localparam int unsigned CapacityDefault = 32;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned StatusWidth = 3;

   typedef logic [StatusWidth-1:0] status_type;

   localparam status_type StNew = 3'd0;
   localparam status_type StExtLo = 3'd1;
   localparam status_type StExtHi = 3'd2;
   localparam status_type StJoin = 3'd3;
   localparam status_type StCovered = 3'd4;
   localparam status_type StFull = 3'd5;
   localparam status_type StListed = 3'd6;
   localparam status_type StEmpty = 3'd7;

   localparam logic OpInsert = 1'b0;
   localparam logic OpList = 1'b1;

   // Each memory word holds one interval: start in the upper half, end in the lower.
   typedef struct packed {
      logic [ValueWidth-1:0] lo;
      logic [ValueWidth-1:0] hi;
   } entry_type;

endpackage

// ===== rtl/isc_ram.sv =====
module isc_ram #(
   parameter int unsigned Width = 64,
   parameter int unsigned Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/interval_set_coalescer.sv =====
// Interval set coalescer.
// Keeps a sorted table of disjoint, non-adjacent closed intervals of signed
// 32-bit values in one synchronous memory (one interval per word).
// Command channel: raise start with req_opcode/req_value while busy is low;
// the item is taken at that edge and busy stays high until the block is
// ready for the next item.
// Insert (opcode 0): the table is scanned from entry 0, one read per cycle,
// until the first start at or above the value; then the block either leaves
// the table as it is (covered or full), rewrites one entry, or shifts the
// tail up by one entry (open a new interval) or down by one entry (join
// two), one entry per cycle. One status item follows with last set. Scan
// and shift share the one read port and the one write port, so together
// they touch each entry once.
// List (opcode 1): one rsp item per stored interval, one per cycle,
// last set on the final one; the final item shows in the same cycle in
// which busy falls. An empty table gives a single 'empty' item in the
// cycle after the accepting edge.
// Results are shown for one cycle with rsp_valid; the receiver cannot stall.
// Reset empties the table at once (count cleared); the memory is not swept.
module interval_set_coalescer #(
   parameter int unsigned Capacity = isc_pkg::CapacityDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_opcode,
   input  logic signed [isc_pkg::ValueWidth-1:0] req_value,
   output logic                                  rsp_valid,
   output isc_pkg::status_type                   rsp_status,
   output logic signed [isc_pkg::ValueWidth-1:0] rsp_range_start,
   output logic signed [isc_pkg::ValueWidth-1:0] rsp_range_end,
   output logic                                  rsp_last
);
   import isc_pkg::*;

   localparam int unsigned AW = $clog2(Capacity);
   localparam int unsigned CW = $clog2(Capacity + 1);
   localparam logic [CW-1:0] CapC = CW'(Capacity);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_LIST  = 6'b000100,
      S_SHUP  = 6'b001000,
      S_SHDN  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;       // address of the read issued last cycle
   logic          rdv_ff, rdv_in;       // a read is in flight
   logic [ValueWidth-1:0] u_ff, u_in;   // biased value
   entry_type     prev_ff, prev_in;     // entry p-1 once seen
   logic          has_prev_ff, has_prev_in;
   entry_type     hold_ff, hold_in;     // entry carried along a shift

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_data;
   logic [CW-1:0] rd_idx;

   logic          out_v;
   status_type    out_st;
   logic [ValueWidth-1:0] out_s, out_e;
   logic          out_l;

   isc_ram #(.Width($bits(entry_type)), .Depth(Capacity)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = rd_idx[AW-1:0];

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      rdv_in = 1'b0;
      u_in = u_ff;
      prev_in = prev_ff;
      has_prev_in = has_prev_ff;
      hold_in = hold_ff;
      rd_idx = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = rd_data;
      out_v = 1'b0;
      out_st = StNew;
      out_s = u_ff;
      out_e = u_ff;
      out_l = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               u_in = {~req_value[ValueWidth-1], req_value[ValueWidth-2:0]};
               has_prev_in = 1'b0;
               idx_in = '0;
               rd_idx = '0;
               if (req_opcode == OpList) begin
                  if (count_ff == '0) begin
                     out_v = 1'b1;
                     out_st = StEmpty;
                     out_s = {1'b1, {(ValueWidth-1){1'b0}}};
                     out_e = {1'b1, {(ValueWidth-1){1'b0}}};
                  end else begin
                     rdv_in = 1'b1;
                     state_in = S_LIST;
                  end
               end else begin
                  rdv_in = (count_ff != '0);
                  state_in = S_SCAN;
               end
            end
         end
         S_LIST: begin
            // one entry out per cycle; next read issued meanwhile
            out_v = 1'b1;
            out_st = StListed;
            out_s = rd_data.lo;
            out_e = rd_data.hi;
            out_l = (idx_ff == count_ff - 1'b1);
            if (out_l) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
               rd_idx = idx_ff + 1'b1;
               rdv_in = 1'b1;
            end
         end
         S_SCAN: begin
            if (rdv_ff && rd_data.lo < u_ff) begin
               // advance past an entry that starts below the value
               prev_in = rd_data;
               has_prev_in = 1'b1;
               if (idx_ff + 1'b1 < count_ff) begin
                  idx_in = idx_ff + 1'b1;
                  rd_idx = idx_ff + 1'b1;
                  rdv_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  rdv_in = 1'b0;
               end
            end else begin
               // decide at p = idx_ff; rd_data valid if rdv_ff
               state_in = S_DONE;
               out_v = 1'b1;
               if (has_prev_ff && prev_ff.hi >= u_ff) begin
                  out_st = StCovered;
                  out_s = prev_ff.lo;
                  out_e = prev_ff.hi;
               end else if (rdv_ff && rd_data.lo == u_ff) begin
                  out_st = StCovered;
                  out_s = rd_data.lo;
                  out_e = rd_data.hi;
               end else if (has_prev_ff && u_ff != '0 && prev_ff.hi == u_ff - 1'b1
                            && rdv_ff && u_ff != '1 && rd_data.lo == u_ff + 1'b1) begin
                  // join: write p-1, then shift down from p+1
                  out_st = StJoin;
                  out_s = prev_ff.lo;
                  out_e = rd_data.hi;
                  wr_en = 1'b1;
                  wr_addr = AW'(idx_ff - 1'b1);
                  wr_data = '{lo: prev_ff.lo, hi: rd_data.hi};
                  count_in = count_ff - 1'b1;
                  if (idx_ff + 1'b1 < count_ff) begin
                     idx_in = idx_ff + 1'b1;
                     rd_idx = idx_ff + 1'b1;
                     rdv_in = 1'b1;
                     state_in = S_SHDN;
                  end
               end else if (has_prev_ff && u_ff != '0 && prev_ff.hi == u_ff - 1'b1) begin
                  out_st = StExtLo;
                  out_s = prev_ff.lo;
                  wr_en = 1'b1;
                  wr_addr = AW'(idx_ff - 1'b1);
                  wr_data = '{lo: prev_ff.lo, hi: u_ff};
               end else if (rdv_ff && u_ff != '1 && rd_data.lo == u_ff + 1'b1) begin
                  out_st = StExtHi;
                  out_e = rd_data.hi;
                  wr_en = 1'b1;
                  wr_addr = AW'(idx_ff);
                  wr_data = '{lo: u_ff, hi: rd_data.hi};
               end else if (count_ff >= CapC) begin
                  out_st = StFull;
               end else begin
                  // new: write at p, carry old p upward
                  out_st = StNew;
                  wr_en = 1'b1;
                  wr_addr = AW'(idx_ff);
                  wr_data = '{lo: u_ff, hi: u_ff};
                  count_in = count_ff + 1'b1;
                  if (rdv_ff) begin
                     hold_in = rd_data;
                     idx_in = idx_ff + 1'b1;
                     if (idx_ff + 1'b1 < count_ff) begin
                        rd_idx = idx_ff + 1'b1;
                        rdv_in = 1'b1;
                     end
                     state_in = S_SHUP;
                  end
               end
            end
         end
         S_SHUP: begin
            // write carried entry at idx, pick up the one that was there
            wr_en = 1'b1;
            wr_addr = AW'(idx_ff);
            wr_data = hold_ff;
            if (rdv_ff) begin
               hold_in = rd_data;
               idx_in = idx_ff + 1'b1;
               if (idx_ff + 1'b1 < count_ff - 1'b1) begin
                  rd_idx = idx_ff + 1'b1;
                  rdv_in = 1'b1;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SHDN: begin
            // move entry idx down to idx-1
            wr_en = 1'b1;
            wr_addr = AW'(idx_ff - 1'b1);
            wr_data = rd_data;
            if (idx_ff + 1'b1 < count_ff + 1'b1) begin
               idx_in = idx_ff + 1'b1;
               rd_idx = idx_ff + 1'b1;
               rdv_in = 1'b1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rdv_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rdv_ff <= rdv_in;
         rsp_valid <= out_v;
      end
      idx_ff <= idx_in;
      u_ff <= u_in;
      prev_ff <= prev_in;
      has_prev_ff <= has_prev_in;
      hold_ff <= hold_in;
      rsp_status <= out_st;
      rsp_range_start <= {~out_s[ValueWidth-1], out_s[ValueWidth-2:0]};
      rsp_range_end <= {~out_e[ValueWidth-1], out_e[ValueWidth-2:0]};
      rsp_last <= out_l;
   end

   // hold busy while the block works; the final item may still be on the outputs
   assign busy = (state_ff != S_IDLE) || (rsp_valid && !rsp_last);
endmodule

// ===== rtl/isc_checker.sv =====
module isc_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input isc_pkg::status_type rsp_status,
   input logic                rsp_last
);
   import isc_pkg::*;

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && !rsp_valid |=> !rsp_valid || $past(start))
      else $error("result without a command");
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != StListed |-> rsp_last)
      else $error("insert result without last");
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("command dropped");
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid || $past(start))
      else $error("result after last");
endmodule

bind interval_set_coalescer isc_checker u_isc_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status),
   .rsp_last   (rsp_last)
);

// ===== sim/interval_set_coalescer_test.sv =====
module interval_set_coalescer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import isc_pkg::*;

   localparam int Cap = CapacityDefault;
   localparam int CycleLimit = 400000;

   // One item sent to the block, and one status item expected back (a list gives one per interval).
   typedef struct {
      logic        opcode;
      logic [31:0] value;
   } cmd_item_type;

   typedef struct {
      status_type  status;
      logic [31:0] range_start;
      logic [31:0] range_end;
      logic        last;
   } status_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic req_opcode = OpInsert;
   logic signed [31:0] req_value = '0;
   logic busy;
   logic rsp_valid;
   status_type rsp_status;
   logic signed [31:0] rsp_range_start;
   logic signed [31:0] rsp_range_end;
   logic rsp_last;

   interval_set_coalescer dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_range_start(rsp_range_start), .rsp_range_end(rsp_range_end),
      .rsp_last(rsp_last)
   );

   cmd_item_type    pending_cmds[$];
   status_item_type expected_status[$];

   // Shadow interval table, kept in biased form so unsigned order is signed order.
   logic [31:0] shadow_lo[Cap];
   logic [31:0] shadow_hi[Cap];
   int          shadow_count = 0;

   int  error_count = 0;
   int  cycle_count = 0;
   int  sent_count = 0;
   int  status_seen = 0;
   int  send_idle_pct = 17;
   bit  send_hold = 1'b0;
   bit [7:0] status_hit = '0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic status_item_type make_status(status_type st, logic [31:0] s,
                                                   logic [31:0] e, logic lst);
      status_item_type r;
      r.status = st;
      r.range_start = s ^ 32'h8000_0000;
      r.range_end = e ^ 32'h8000_0000;
      r.last = lst;
      return r;
   endfunction

   // Apply one accepted item to the shadow table and queue its status items.
   task automatic predict_table_update(cmd_item_type c);
      int p;
      logic [31:0] u;
      bit lo_ok, hi_ok, join_lo, join_hi;
      p = 0;
      u = c.value ^ 32'h8000_0000;
      if (c.opcode == OpList) begin
         if (shadow_count == 0) begin
            expected_status.push_back(make_status(StEmpty, 32'h8000_0000,
                                                  32'h8000_0000, 1'b1));
         end else begin
            for (int i = 0; i < shadow_count; i++)
               expected_status.push_back(make_status(StListed, shadow_lo[i],
                  shadow_hi[i], i == shadow_count - 1));
         end
         return;
      end
      while (p < shadow_count && shadow_lo[p] < u) p++;
      lo_ok = p > 0;
      hi_ok = p < shadow_count;
      if (lo_ok && shadow_hi[p-1] >= u) begin
         expected_status.push_back(make_status(StCovered, shadow_lo[p-1],
                                               shadow_hi[p-1], 1'b1));
         return;
      end
      if (hi_ok && shadow_lo[p] == u) begin
         expected_status.push_back(make_status(StCovered, shadow_lo[p],
                                               shadow_hi[p], 1'b1));
         return;
      end
      join_lo = lo_ok && u != 32'h0 && shadow_hi[p-1] == u - 1;
      join_hi = hi_ok && u != 32'hFFFF_FFFF && shadow_lo[p] == u + 1;
      if (join_lo && join_hi) begin
         shadow_hi[p-1] = shadow_hi[p];
         for (int i = p; i + 1 < shadow_count; i++) begin
            shadow_lo[i] = shadow_lo[i+1];
            shadow_hi[i] = shadow_hi[i+1];
         end
         shadow_count--;
         expected_status.push_back(make_status(StJoin, shadow_lo[p-1],
                                               shadow_hi[p-1], 1'b1));
      end else if (join_lo) begin
         shadow_hi[p-1] = u;
         expected_status.push_back(make_status(StExtLo, shadow_lo[p-1], u, 1'b1));
      end else if (join_hi) begin
         shadow_lo[p] = u;
         expected_status.push_back(make_status(StExtHi, u, shadow_hi[p], 1'b1));
      end else if (shadow_count >= Cap) begin
         expected_status.push_back(make_status(StFull, u, u, 1'b1));
      end else begin
         for (int i = shadow_count; i > p; i--) begin
            shadow_lo[i] = shadow_lo[i-1];
            shadow_hi[i] = shadow_hi[i-1];
         end
         shadow_lo[p] = u;
         shadow_hi[p] = u;
         shadow_count++;
         expected_status.push_back(make_status(StNew, u, u, 1'b1));
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   task automatic queue_cmd(logic op, logic [31:0] v);
      cmd_item_type c;
      c.opcode = op;
      c.value = v;
      pending_cmds.push_back(c);
   endtask

   // Driver: hold start until the block takes the item, then advance.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (start && !busy) begin
            predict_table_update('{req_opcode, req_value});
            sent_count <= sent_count + 1;
         end
         if (start && busy) begin
            // hold the item until taken
         end else if (pending_cmds.size() > 0 && !send_hold &&
                      $urandom_range(99) >= send_idle_pct) begin
            cmd_item_type c;
            c = pending_cmds.pop_front();
            start <= 1'b1;
            req_opcode <= c.opcode;
            req_value <= c.value;
         end else begin
            start <= 1'b0;
            req_opcode <= 1'($urandom_range(1));
            req_value <= $urandom;
         end
      end
   end

   // Monitor: every strobed result must match the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected result, status", 32'(rsp_status), 32'h0);
         end else begin
            status_item_type w;
            w = expected_status.pop_front();
            if (rsp_status != w.status)
               report_mismatch("status", 32'(rsp_status), 32'(w.status));
            if (rsp_range_start != w.range_start)
               report_mismatch("range_start", rsp_range_start, w.range_start);
            if (rsp_range_end != w.range_end)
               report_mismatch("range_end", rsp_range_end, w.range_end);
            if (rsp_last != w.last)
               report_mismatch("last", 32'(rsp_last), 32'(w.last));
            status_hit[w.status] = 1'b1;
            status_seen++;
         end
      end
   end

   // Wait until queue and block are both drained.
   task automatic drain_all();
      while (pending_cmds.size() > 0 || start || expected_status.size() > 0)
         @(posedge clock);
   endtask

   // Random well-formed traffic: values clustered in a small window so that
   // extensions, joins, covered hits and the full table all come up often.
   task automatic random_burst(int n, logic [31:0] base, int span);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 8) queue_cmd(OpList, $urandom);
         else if ($urandom_range(99) < 10) queue_cmd(OpInsert, $urandom);
         else queue_cmd(OpInsert, base + $urandom_range(span));
      end
   endtask

   // Timeout guard.
   always @(posedge clock) begin
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty listing, edge values without wrap, all status kinds but full.
      queue_cmd(OpList, 32'h0);
      queue_cmd(OpInsert, 32'h7FFF_FFFF);
      queue_cmd(OpInsert, 32'h8000_0000);
      queue_cmd(OpInsert, 32'h7FFF_FFFE);   // extend upper
      queue_cmd(OpInsert, 32'h8000_0001);   // extend lower
      queue_cmd(OpInsert, 32'h8000_0000);   // covered
      queue_cmd(OpInsert, 32'h0000_0010);
      queue_cmd(OpInsert, 32'h0000_0012);
      queue_cmd(OpInsert, 32'h0000_0011);   // join
      queue_cmd(OpInsert, 32'hFFFF_FFFF);
      queue_cmd(OpInsert, 32'h0000_0000);   // extends the interval at -1
      queue_cmd(OpInsert, 32'h0000_0012);   // covered at end
      queue_cmd(OpList, 32'hFFFF_FFFF);
      drain_all();

      // Fill to capacity with spaced values, then overflow.
      for (int i = 0; i < Cap; i++) queue_cmd(OpInsert, 32'h0100_0000 + 4 * i);
      queue_cmd(OpInsert, 32'h0200_0000);   // full
      queue_cmd(OpInsert, 32'h0100_0001);   // still extends
      queue_cmd(OpList, 32'h0);
      // wait until every expected result is in, then pause the sender
      drain_all();
      send_hold = 1'b1;
      repeat (20) @(posedge clock);
      send_hold = 1'b0;

      random_burst(70, 32'h0100_0000, 140);
      drain_all();
      send_idle_pct = 56;
      random_burst(70, 32'hFFFF_FFC0, 120);
      drain_all();
      send_idle_pct = 0;
      random_burst(70, 32'h7FFF_FFC0, 70);
      queue_cmd(OpList, 32'h0);
      drain_all();

      repeat (80) @(posedge clock);
      $display("Ran %0d items, checked %0d results; status kinds seen mask %b",
               sent_count, status_seen, status_hit);
      if (error_count == 0 && expected_status.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
